@@ src/tls_pkg.sv @@
// shared constants and controller/datapath handshake structs for the linear solver
// no dependencies
package tls_pkg;

    localparam int NUM_W   = 16;
    localparam int IDENT_W = 8;
    localparam int SOL_W   = 48;

    localparam logic [1:0] TK_NUMBER = 2'd0;
    localparam logic [1:0] TK_IDENT  = 2'd1;
    localparam logic [1:0] TK_SYMBOL = 2'd2;

    localparam logic [7:0] SYM_MINUS  = 8'h2d;
    localparam logic [7:0] SYM_EQUALS = 8'h3d;
    localparam logic [7:0] SYM_CARET  = 8'h5e;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_NUM   = 3'd1;
    localparam logic [2:0] PH_VAR   = 3'd2;
    localparam logic [2:0] PH_CARET = 3'd3;

    typedef struct packed {
        logic       tok_take;
        logic       solve_start;
        logic       mul_issue;
        logic [2:0] mul_sel;
        logic       mul_acc;
        logic [2:0] acc_sel;
        logic       div_load;
        logic       div_second;
        logic       div_step;
        logic       sol0_save;
        logic       res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic det_zero;
    } t_dp_sts;

endpackage

@@ src/tls_if.sv @@
// token and result channel interfaces with valid/ready handshake
// depends on tls_pkg
interface tls_tok_if;
    logic                         valid;
    logic                         ready;
    logic                         equation_index;
    logic [1:0]                   token_kind;
    logic [tls_pkg::NUM_W-1:0]    number_value;
    logic [tls_pkg::IDENT_W-1:0]  identifier_code;
    logic [7:0]                   symbol_char;
    logic                         final_token;

    modport source (output valid, equation_index, token_kind, number_value,
                    identifier_code, symbol_char, final_token, input ready);
    modport sink (input valid, equation_index, token_kind, number_value,
                  identifier_code, symbol_char, final_token, output ready);
endinterface

interface tls_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [tls_pkg::SOL_W-1:0]   first_solution;
    logic signed [tls_pkg::SOL_W-1:0]   second_solution;
    logic [tls_pkg::IDENT_W-1:0]        first_var_code;
    logic [tls_pkg::IDENT_W-1:0]        second_var_code;
    logic                               not_solvable;

    modport source (output valid, first_solution, second_solution, first_var_code,
                    second_var_code, not_solvable, input ready);
    modport sink (input valid, first_solution, second_solution, first_var_code,
                  second_var_code, not_solvable, output ready);
endinterface

@@ src/tls_datapath.sv @@
// token folding registers, shared multiplier, restoring divider and result registers
// depends on tls_pkg
module tls_datapath #(
    parameter int COEF_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tls_pkg::t_dp_cmd                  i_cmd,
    output tls_pkg::t_dp_sts                  o_sts,
    input  logic                              i_eq,
    input  logic [1:0]                        i_kind,
    input  logic [tls_pkg::NUM_W-1:0]         i_num,
    input  logic [tls_pkg::IDENT_W-1:0]       i_code,
    input  logic [7:0]                        i_sym,
    input  logic                              i_final,
    output logic signed [tls_pkg::SOL_W-1:0]  o_sol0,
    output logic signed [tls_pkg::SOL_W-1:0]  o_sol1,
    output logic [tls_pkg::IDENT_W-1:0]       o_code0,
    output logic [tls_pkg::IDENT_W-1:0]       o_code1,
    output logic                              o_not_solvable
);

    localparam int C  = COEF_BITS;
    localparam int PW = 2 * C + 1;
    localparam int MW = 2 * C;
    localparam int QW = 2 * C + FRAC_BITS;
    localparam int XW = (QW > tls_pkg::SOL_W) ? QW : tls_pkg::SOL_W + 1;
    localparam int NW = tls_pkg::NUM_W;
    localparam int IW = tls_pkg::IDENT_W;

    typedef struct packed {
        logic [3:0][C-1:0]  lin;
        logic [1:0][C-1:0]  cst;
        logic [1:0][IW-1:0] codes;
        logic [1:0]         seen;
        logic               neg;
        logic               rs;
        logic [NW-1:0]      pmag;
        logic [IW-1:0]      pvar;
        logic [2:0]         phase;
        logic               eq;
    } t_fold;

    function automatic logic [C-1:0] f_sat(logic [C-1:0] acc, logic neg, logic [NW-1:0] mag);
        logic signed [C:0] a;
        logic signed [C:0] m;
        logic signed [C:0] r;
        a = $signed({acc[C-1], acc});
        m = $signed({{(C+1-NW){1'b0}}, mag});
        r = neg ? a - m : a + m;
        if (r[C] != r[C-1]) begin
            return r[C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
        end
        return r[C-1:0];
    endfunction

    function automatic t_fold f_reset();
        t_fold r;
        r = '0;
        r.pmag = NW'(1);
        r.phase = tls_pkg::PH_IDLE;
        return r;
    endfunction

    function automatic t_fold f_add(t_fold s, logic is_lin, logic [IW-1:0] code,
                                    logic [NW-1:0] mag);
        t_fold r;
        logic  sg;
        logic  slot;
        logic  ok;
        r = s;
        sg = s.neg ^ s.rs;
        slot = 1'b0;
        ok = 1'b1;
        if (!is_lin) begin
            r.cst[s.eq] = f_sat(s.cst[s.eq], sg, mag);
        end else begin
            if (s.seen[0] && s.codes[0] == code) slot = 1'b0;
            else if (s.seen[1] && s.codes[1] == code) slot = 1'b1;
            else if (!s.seen[0]) slot = 1'b0;
            else if (!s.seen[1]) slot = 1'b1;
            else ok = 1'b0;
            if (ok) begin
                r.seen[slot] = 1'b1;
                r.codes[slot] = code;
                r.lin[{s.eq, slot}] = f_sat(s.lin[{s.eq, slot}], sg, mag);
            end
        end
        return r;
    endfunction

    function automatic t_fold f_commit(t_fold s);
        t_fold r;
        r = s;
        if (s.phase != tls_pkg::PH_IDLE) begin
            r = f_add(s, s.phase != tls_pkg::PH_NUM, s.pvar, s.pmag);
            r.neg = 1'b0;
            r.phase = tls_pkg::PH_IDLE;
            r.pmag = NW'(1);
        end
        return r;
    endfunction

    function automatic logic [tls_pkg::SOL_W-1:0] f_sol(logic [QW-1:0] q, logic neg);
        logic [XW-1:0] qx;
        logic [XW-1:0] lim;
        logic [XW-1:0] v;
        qx = XW'(q);
        lim = (XW'(1) << (tls_pkg::SOL_W - 1)) - XW'(!neg);
        v = (qx > lim) ? lim : qx;
        return neg ? -v[tls_pkg::SOL_W-1:0] : v[tls_pkg::SOL_W-1:0];
    endfunction

    t_fold r_fold, n_fold, s_tok, s_fin;
    logic  lo_sel;

    always_comb begin
        s_tok = r_fold;
        // equation change closes the pending term of the old one
        if (i_eq != s_tok.eq) begin
            s_tok = f_commit(s_tok);
            s_tok.neg = 1'b0;
            s_tok.rs = 1'b0;
            s_tok.eq = i_eq;
        end
        case (i_kind)
            tls_pkg::TK_NUMBER: begin
                if (s_tok.phase == tls_pkg::PH_CARET) begin
                    s_tok = f_add(s_tok, i_num != '0, s_tok.pvar, s_tok.pmag);
                    s_tok.neg = 1'b0;
                    s_tok.phase = tls_pkg::PH_IDLE;
                    s_tok.pmag = NW'(1);
                end else begin
                    s_tok = f_commit(s_tok);
                    s_tok.pmag = i_num;
                    s_tok.phase = tls_pkg::PH_NUM;
                end
            end
            tls_pkg::TK_IDENT: begin
                if (s_tok.phase != tls_pkg::PH_NUM) s_tok = f_commit(s_tok);
                s_tok.pvar = i_code;
                s_tok.phase = tls_pkg::PH_VAR;
            end
            tls_pkg::TK_SYMBOL: begin
                if (i_sym == tls_pkg::SYM_CARET && s_tok.phase == tls_pkg::PH_VAR) begin
                    s_tok.phase = tls_pkg::PH_CARET;
                end else begin
                    s_tok = f_commit(s_tok);
                    if (i_sym == tls_pkg::SYM_MINUS) s_tok.neg = !s_tok.neg;
                    else if (i_sym == tls_pkg::SYM_EQUALS) s_tok.rs = 1'b1;
                end
            end
            default: ;
        endcase
        s_fin = f_commit(s_tok);
        lo_sel = s_fin.seen[0] && s_fin.seen[1] && (s_fin.codes[1] < s_fin.codes[0]);
        n_fold = r_fold;
        if (i_cmd.tok_take) n_fold = i_final ? f_reset() : s_tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fold <= f_reset();
        else r_fold <= n_fold;
    end

    // solve operands, sorted by variable code
    logic signed [C-1:0] r_alo, r_ahi, r_blo, r_bhi, r_c0, r_c1;
    logic [IW-1:0]       r_code0, r_code1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.solve_start) begin
            r_alo <= $signed(s_fin.lin[{1'b0, lo_sel}]);
            r_ahi <= $signed(s_fin.lin[{1'b0, !lo_sel}]);
            r_blo <= $signed(s_fin.lin[{1'b1, lo_sel}]);
            r_bhi <= $signed(s_fin.lin[{1'b1, !lo_sel}]);
            r_c0 <= $signed(s_fin.cst[0]);
            r_c1 <= $signed(s_fin.cst[1]);
            r_code0 <= s_fin.seen[lo_sel] ? s_fin.codes[lo_sel] : '0;
            r_code1 <= s_fin.seen[!lo_sel] ? s_fin.codes[!lo_sel] : '0;
        end
    end

    // one shared multiplier, six products in turn
    logic signed [C-1:0]  mx, my;
    logic signed [MW-1:0] r_prod;
    logic signed [PW-1:0] r_det, r_nu, r_nv, pext;

    always_comb begin
        case (i_cmd.mul_sel)
            3'd0: begin mx = r_alo; my = r_bhi; end
            3'd1: begin mx = r_blo; my = r_ahi; end
            3'd2: begin mx = r_ahi; my = r_c1;  end
            3'd3: begin mx = r_bhi; my = r_c0;  end
            3'd4: begin mx = r_blo; my = r_c0;  end
            default: begin mx = r_alo; my = r_c1; end
        endcase
        pext = PW'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_issue) r_prod <= mx * my;
        if (i_cmd.mul_acc) begin
            case (i_cmd.acc_sel)
                3'd0: r_det <= pext;
                3'd1: r_det <= r_det - pext;
                3'd2: r_nu <= pext;
                3'd3: r_nu <= r_nu - pext;
                3'd4: r_nv <= pext;
                default: r_nv <= r_nv - pext;
            endcase
        end
    end

    assign o_sts.det_zero = (r_det == '0);

    // restoring divider on magnitudes, one quotient bit a cycle
    logic [MW-1:0]  r_dvs, r_rem, rem_nx;
    logic [QW-1:0]  r_dvd, r_quo;
    logic           r_qneg, qbit;
    logic [MW:0]    trial;
    logic signed [PW-1:0] num_sel, num_abs, det_abs;

    always_comb begin
        num_sel = i_cmd.div_second ? r_nv : r_nu;
        num_abs = num_sel[PW-1] ? -num_sel : num_sel;
        det_abs = r_det[PW-1] ? -r_det : r_det;
        trial = {r_rem, r_dvd[QW-1]};
        qbit = (trial >= {1'b0, r_dvs});
        rem_nx = qbit ? MW'(trial - {1'b0, r_dvs}) : trial[MW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dvs <= det_abs[MW-1:0];
            r_dvd <= QW'(num_abs[MW-1:0]) << FRAC_BITS;
            r_rem <= '0;
            r_quo <= '0;
            r_qneg <= num_sel[PW-1] ^ r_det[PW-1];
        end else if (i_cmd.div_step) begin
            r_rem <= rem_nx;
            r_dvd <= r_dvd << 1;
            r_quo <= {r_quo[QW-2:0], qbit};
        end
    end

    logic signed [tls_pkg::SOL_W-1:0] r_sol0, r_sol1;
    logic                             r_ns;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sol0_save) r_sol0 <= f_sol(r_quo, r_qneg);
        if (i_cmd.res_load) begin
            if (o_sts.det_zero) begin
                r_sol0 <= '0;
                r_sol1 <= '0;
                r_ns <= 1'b1;
            end else begin
                r_sol1 <= f_sol(r_quo, r_qneg);
                r_ns <= 1'b0;
            end
        end
    end

    assign o_sol0 = r_sol0;
    assign o_sol1 = r_sol1;
    assign o_code0 = r_code0;
    assign o_code1 = r_code1;
    assign o_not_solvable = r_ns;

endmodule

@@ src/tls_ctrl.sv @@
// sequencer for token intake, product steps, up to two divisions and result transfer
// depends on tls_pkg
module tls_ctrl #(
    parameter int QUO_BITS = 80
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok_valid,
    input  logic             i_tok_final,
    output logic             o_tok_ready,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    input  tls_pkg::t_dp_sts i_sts,
    output tls_pkg::t_dp_cmd o_cmd
);

    localparam int CW = ($clog2(QUO_BITS + 1) > 3) ? $clog2(QUO_BITS + 1) : 3;

    localparam logic [2:0] S_TOKEN = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_NEXT  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_pass, n_pass;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_pass = r_pass;
        o_cmd = '0;
        o_tok_ready = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_TOKEN: begin
                o_tok_ready = 1'b1;
                if (i_tok_valid) begin
                    o_cmd.tok_take = 1'b1;
                    if (i_tok_final) begin
                        o_cmd.solve_start = 1'b1;
                        n_state = S_MUL;
                        n_cnt = '0;
                    end
                end
            end
            S_MUL: begin
                if (r_cnt < CW'(6)) begin
                    o_cmd.mul_issue = 1'b1;
                    o_cmd.mul_sel = r_cnt[2:0];
                end
                if (r_cnt != '0) begin
                    o_cmd.mul_acc = 1'b1;
                    o_cmd.acc_sel = r_cnt[2:0] - 3'd1;
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(6)) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.det_zero) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_load = 1'b1;
                    n_cnt = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(QUO_BITS - 1)) n_state = S_NEXT;
            end
            S_NEXT: begin
                if (!r_pass) begin
                    o_cmd.sol0_save = 1'b1;
                    o_cmd.div_load = 1'b1;
                    o_cmd.div_second = 1'b1;
                    n_pass = 1'b1;
                    n_cnt = '0;
                    n_state = S_DIV;
                end else begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_res_valid = 1'b1;
                // result registers part the sides, only a final token has to wait
                o_tok_ready = !i_tok_final;
                if (i_tok_valid && !i_tok_final) o_cmd.tok_take = 1'b1;
                if (i_res_ready) begin
                    n_pass = 1'b0;
                    n_state = S_TOKEN;
                end
            end
            default: n_state = S_TOKEN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TOKEN;
            r_cnt <= '0;
            r_pass <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_pass <= n_pass;
        end
    end

    a_final_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.tok_take && i_tok_final |=> r_state == S_MUL)
        else $error("final token did not start the solve");
    a_no_div_on_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_load |-> !i_sts.det_zero)
        else $error("division started with zero determinant");
    a_load_then_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |=> o_res_valid)
        else $error("result loaded but not offered");
    a_second_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load && !i_sts.det_zero |-> r_pass)
        else $error("result taken before second division");

endmodule

@@ src/two_equation_linear_solver.sv @@
// two-equation linear solver: one token per cycle outside a solve, Cramer's rule solve after the final token
// solve time is set by the single shared multiplier and the bit-serial divider, QW = 2*COEF_BITS+FRAC_BITS
// throughput: one token per cycle outside a solve; while a result waits only a final token stalls
// reset: synchronous active-low i_rst_n clears all equation state, fold state also clears after each solve
// depends on tls_pkg, tls_if, tls_ctrl, tls_datapath
module two_equation_linear_solver #(
    parameter int COEF_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tls_tok_if.sink    i_tok,
    tls_res_if.source  o_res
);

    // quotient width of the fixed-point division
    localparam int QW = 2 * COEF_BITS + FRAC_BITS;

    tls_pkg::t_dp_cmd cmd;
    tls_pkg::t_dp_sts sts;

    // controller: token intake, product sequence, up to two divisions, result transfer
    tls_ctrl #(
        .QUO_BITS(QW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (i_tok.valid),
        .i_tok_final (i_tok.final_token),
        .o_tok_ready (i_tok.ready),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath: coefficient folding, determinant and numerators, divider
    tls_datapath #(
        .COEF_BITS(COEF_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_eq           (i_tok.equation_index),
        .i_kind         (i_tok.token_kind),
        .i_num          (i_tok.number_value),
        .i_code         (i_tok.identifier_code),
        .i_sym          (i_tok.symbol_char),
        .i_final        (i_tok.final_token),
        .o_sol0         (o_res.first_solution),
        .o_sol1         (o_res.second_solution),
        .o_code0        (o_res.first_var_code),
        .o_code1        (o_res.second_var_code),
        .o_not_solvable (o_res.not_solvable)
    );

endmodule
